### src/fvsc_pkg.sv
`timescale 1ns / 1ps

package fvsc_pkg;

   localparam int LEVEL_BITS = 16;
   localparam int TIMER_BITS = 32;

   localparam int CMD_W    = 3;
   localparam int LVL_W    = 16;
   localparam int TICK_W   = 32;
   localparam int MISS_W   = 8;
   localparam int REASON_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [TIMER_BITS-1:0] timer_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_REPORT     = 3'd1,
      CMD_MANUAL_ON  = 3'd2,
      CMD_MANUAL_OFF = 3'd3,
      CMD_REMOTE_OFF = 3'd4
   } cmd_type;

   typedef enum logic [REASON_W-1:0] {
      REASON_LEVEL  = 2'd0,
      REASON_MANUAL = 2'd1,
      REASON_REMOTE = 2'd2
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_LEVEL  = 3'd0,
      CSR_MIN_SAFE    = 3'd1,
      CSR_MAX_RUNTIME = 3'd2,
      CSR_LOCKOUT     = 3'd3,
      CSR_WATCHDOG    = 3'd4,
      CSR_MISS_LIMIT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LVL_W-1:0]  stop_level;
      logic [LVL_W-1:0]  start_level;
      logic [TICK_W-1:0] max_runtime_ticks;
      logic [TICK_W-1:0] lockout_ticks;
      logic [TICK_W-1:0] watchdog_ticks;
      logic [MISS_W-1:0] miss_limit;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [LVL_W-1:0] water_level;
      logic             float_one_full;
      logic             float_two_full;
      logic             level_trusted;
      logic             report_malformed;
   } item_type;

   typedef struct packed {
      logic                valve_on;
      logic [MISS_W-1:0]   miss_count;
      logic                locked_out;
      logic                report_valid;
      logic                report_on;
      logic [REASON_W-1:0] report_reason;
   } result_type;

   localparam logic [LVL_W-1:0]  RST_STOP_LEVEL  = 16'd800;
   localparam logic [LVL_W-1:0]  RST_MIN_SAFE    = 16'd600;
   localparam logic [TICK_W-1:0] RST_MAX_RUNTIME = 32'd600000;
   localparam logic [TICK_W-1:0] RST_LOCKOUT     = 32'd86400000;
   localparam logic [TICK_W-1:0] RST_WATCHDOG    = 32'd1500;
   localparam logic [MISS_W-1:0] RST_MISS_LIMIT  = 8'd3;

   function automatic timer_type sat_inc(input timer_type cnt);
      sat_inc = (cnt == '1) ? cnt : cnt + timer_type'(1);
   endfunction

endpackage

### src/fvsc_csr.sv
`timescale 1ns / 1ps

module fvsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fvsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fvsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output fvsc_pkg::cfg_type                   cfg
);

   fvsc_pkg::cfg_type cfg_ff;
   fvsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (fvsc_pkg::csr_index_type'(csr_index))
            fvsc_pkg::CSR_STOP_LEVEL:
               cfg_in.stop_level = csr_wdata[fvsc_pkg::LVL_W-1:0];
            fvsc_pkg::CSR_MIN_SAFE:
               cfg_in.start_level = csr_wdata[fvsc_pkg::LVL_W-1:0];
            fvsc_pkg::CSR_MAX_RUNTIME:
               cfg_in.max_runtime_ticks = csr_wdata[fvsc_pkg::TICK_W-1:0];
            fvsc_pkg::CSR_LOCKOUT:
               cfg_in.lockout_ticks = csr_wdata[fvsc_pkg::TICK_W-1:0];
            fvsc_pkg::CSR_WATCHDOG:
               cfg_in.watchdog_ticks = csr_wdata[fvsc_pkg::TICK_W-1:0];
            fvsc_pkg::CSR_MISS_LIMIT:
               cfg_in.miss_limit = csr_wdata[fvsc_pkg::MISS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_level        <= fvsc_pkg::RST_STOP_LEVEL;
         cfg_ff.start_level       <= fvsc_pkg::RST_MIN_SAFE;
         cfg_ff.max_runtime_ticks <= fvsc_pkg::RST_MAX_RUNTIME;
         cfg_ff.lockout_ticks     <= fvsc_pkg::RST_LOCKOUT;
         cfg_ff.watchdog_ticks    <= fvsc_pkg::RST_WATCHDOG;
         cfg_ff.miss_limit        <= fvsc_pkg::RST_MISS_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/fvsc_core.sv
`timescale 1ns / 1ps

module fvsc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  fvsc_pkg::cfg_type     cfg,
   input  logic                  advance,
   input  fvsc_pkg::item_type    item,
   output fvsc_pkg::result_type  result
);

   logic                           valve_ff, valve_in;
   logic [fvsc_pkg::MISS_W-1:0]    miss_ff, miss_in;
   logic                           lk_act_ff, lk_act_in;
   fvsc_pkg::timer_type            lk_cnt_ff, lk_cnt_in;
   logic                           wd_arm_ff, wd_arm_in;
   fvsc_pkg::timer_type            wd_cnt_ff, wd_cnt_in;
   logic                           rt_arm_ff, rt_arm_in;
   fvsc_pkg::timer_type            rt_cnt_ff, rt_cnt_in;

   fvsc_pkg::level_type            level;
   fvsc_pkg::level_type            full_lvl;
   fvsc_pkg::level_type            min_lvl;
   fvsc_pkg::timer_type            lk_adv, wd_adv, rt_adv;
   logic                           rv, ron;
   logic [fvsc_pkg::REASON_W-1:0]  rr;
   logic                           bad_report;
   logic                           open_ok;

   assign level    = fvsc_pkg::level_type'(32'(item.water_level));
   assign full_lvl = fvsc_pkg::level_type'(32'(cfg.stop_level));
   assign min_lvl  = fvsc_pkg::level_type'(32'(cfg.start_level));
   assign lk_adv   = fvsc_pkg::sat_inc(lk_cnt_ff);
   assign wd_adv   = fvsc_pkg::sat_inc(wd_cnt_ff);
   assign rt_adv   = fvsc_pkg::sat_inc(rt_cnt_ff);
   assign bad_report = item.report_malformed | item.float_one_full | item.float_two_full |
                       (level >= full_lvl) | ~item.level_trusted;

   always_comb begin
      valve_in  = valve_ff;
      miss_in   = miss_ff;
      lk_act_in = lk_act_ff;
      lk_cnt_in = lk_cnt_ff;
      wd_arm_in = wd_arm_ff;
      wd_cnt_in = wd_cnt_ff;
      rt_arm_in = rt_arm_ff;
      rt_cnt_in = rt_cnt_ff;
      rv        = 1'b0;
      ron       = 1'b0;
      rr        = fvsc_pkg::REASON_LEVEL;
      open_ok   = 1'b0;

      case (fvsc_pkg::cmd_type'(item.command))
         fvsc_pkg::CMD_TICK: begin
            if (lk_act_ff) begin
               if (lk_adv >= cfg.lockout_ticks) begin
                  lk_act_in = 1'b0;
                  lk_cnt_in = '0;
               end else begin
                  lk_cnt_in = lk_adv;
               end
            end
            if (wd_arm_ff) begin
               if (wd_adv >= cfg.watchdog_ticks) begin
                  wd_cnt_in = '0;
                  if (miss_ff != '1) begin
                     miss_in = miss_ff + 1'b1;
                  end
                  if (miss_in >= cfg.miss_limit && valve_ff) begin
                     valve_in  = 1'b0;
                     lk_act_in = 1'b1;
                     lk_cnt_in = '0;
                  end
               end else begin
                  wd_cnt_in = wd_adv;
               end
            end
            if (rt_arm_ff) begin
               if (rt_adv >= cfg.max_runtime_ticks) begin
                  rt_arm_in = 1'b0;
                  rt_cnt_in = '0;
                  valve_in  = 1'b0;
                  lk_act_in = 1'b1;
                  lk_cnt_in = '0;
               end else begin
                  rt_cnt_in = rt_adv;
               end
            end
         end
         fvsc_pkg::CMD_REPORT: begin
            wd_arm_in = 1'b1;
            wd_cnt_in = '0;
            if (miss_ff != '0) begin
               miss_in = miss_ff - 1'b1;
            end
            if (!lk_act_ff) begin
               if (bad_report) begin
                  valve_in  = 1'b0;
                  lk_act_in = 1'b1;
                  lk_cnt_in = '0;
               end else if (level <= min_lvl && !valve_ff) begin
                  open_ok = (miss_in < cfg.miss_limit);
                  rv      = 1'b1;
                  ron     = 1'b1;
                  rr      = fvsc_pkg::REASON_LEVEL;
               end
            end
         end
         fvsc_pkg::CMD_MANUAL_ON: begin
            open_ok = (miss_ff < cfg.miss_limit) && !lk_act_ff;
            rv      = 1'b1;
            ron     = 1'b1;
            rr      = fvsc_pkg::REASON_MANUAL;
         end
         fvsc_pkg::CMD_MANUAL_OFF: begin
            valve_in  = 1'b0;
            lk_act_in = 1'b1;
            lk_cnt_in = '0;
            rv        = 1'b1;
            rr        = fvsc_pkg::REASON_MANUAL;
         end
         fvsc_pkg::CMD_REMOTE_OFF: begin
            valve_in  = 1'b0;
            lk_act_in = 1'b1;
            lk_cnt_in = '0;
            rv        = 1'b1;
            rr        = fvsc_pkg::REASON_REMOTE;
         end
         default: ;
      endcase

      if (open_ok) begin
         valve_in  = 1'b1;
         miss_in   = '0;
         rt_arm_in = 1'b1;
         rt_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valve_ff  <= 1'b0;
         miss_ff   <= '0;
         lk_act_ff <= 1'b0;
         lk_cnt_ff <= '0;
         wd_arm_ff <= 1'b0;
         wd_cnt_ff <= '0;
         rt_arm_ff <= 1'b0;
         rt_cnt_ff <= '0;
      end else if (advance) begin
         valve_ff  <= valve_in;
         miss_ff   <= miss_in;
         lk_act_ff <= lk_act_in;
         lk_cnt_ff <= lk_cnt_in;
         wd_arm_ff <= wd_arm_in;
         wd_cnt_ff <= wd_cnt_in;
         rt_arm_ff <= rt_arm_in;
         rt_cnt_ff <= rt_cnt_in;
      end
   end

   assign result.valve_on      = valve_in;
   assign result.miss_count    = miss_in;
   assign result.locked_out    = lk_act_in;
   assign result.report_valid  = rv;
   assign result.report_on     = ron;
   assign result.report_reason = rr;

endmodule

### src/fill_valve_safety_controller_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// req       req_valid/req_ready   command, level, float switches, trusted, malformed
// rsp       rsp_valid/rsp_ready   valve, miss count, lockout, announcement
// csr       csr_we                csr_index, csr_wdata (no read-back)
// One beat per cycle sustained while rsp is not stalled; a req beat taken is held in the input
// register, then loaded into the result register that drives rsp_valid once it is empty or draining.
// The state update is one pass of compare-and-increment logic on the three timers.
// Reset is synchronous; it clears state and loads the register defaults.
// A stalled rsp holds its beat; req takes a beat into the input register only if it is empty, then stalls.

module fill_valve_safety_controller_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [fvsc_pkg::CMD_W-1:0]              req_command,
   input  logic [fvsc_pkg::LVL_W-1:0]              req_water_level,
   input  logic                                    req_float_one_full,
   input  logic                                    req_float_two_full,
   input  logic                                    req_level_trusted,
   input  logic                                    req_report_malformed,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valve_on,
   output logic [fvsc_pkg::MISS_W-1:0]             rsp_miss_count,
   output logic                                    rsp_locked_out,
   output logic                                    rsp_report_valid,
   output logic                                    rsp_report_on,
   output logic [fvsc_pkg::REASON_W-1:0]           rsp_report_reason,
   input  logic                                    csr_we,
   input  logic [fvsc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fvsc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   fvsc_pkg::cfg_type     cfg;
   fvsc_pkg::item_type    item_ff;
   fvsc_pkg::result_type  result;
   fvsc_pkg::result_type  out_ff;
   logic                  in_valid_ff;
   logic                  out_valid_ff;
   logic                  advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   fvsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fvsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.command          <= req_command;
         item_ff.water_level      <= req_water_level;
         item_ff.float_one_full   <= req_float_one_full;
         item_ff.float_two_full   <= req_float_two_full;
         item_ff.level_trusted    <= req_level_trusted;
         item_ff.report_malformed <= req_report_malformed;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_valve_on      = out_ff.valve_on;
   assign rsp_miss_count    = out_ff.miss_count;
   assign rsp_locked_out    = out_ff.locked_out;
   assign rsp_report_valid  = out_ff.report_valid;
   assign rsp_report_on     = out_ff.report_on;
   assign rsp_report_reason = out_ff.report_reason;

endmodule

### src/fvsc_checker.sv
`timescale 1ns / 1ps

module fvsc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic                                    rsp_valve_on,
   input logic [fvsc_pkg::MISS_W-1:0]             rsp_miss_count,
   input logic                                    rsp_locked_out,
   input logic                                    rsp_report_valid,
   input logic                                    rsp_report_on,
   input logic [fvsc_pkg::REASON_W-1:0]           rsp_report_reason
);

   a_open_not_locked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valve_on |-> !rsp_locked_out)
      else $error("valve open while locked out");

   a_quiet_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |->
         !rsp_report_on && rsp_report_reason == fvsc_pkg::REASON_LEVEL)
      else $error("announcement fields set without announcement");

   a_remote_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid && rsp_report_reason == fvsc_pkg::REASON_REMOTE |->
         !rsp_report_on && !rsp_valve_on && rsp_locked_out)
      else $error("remote off did not close and lock");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_valve_on) && $stable(rsp_miss_count))
      else $error("stalled response beat changed");

endmodule

bind fill_valve_safety_controller_unit fvsc_checker u_fvsc_checker (.*);
